// ----- rtl/core/sha1md_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 digest block.
// Used by sha1md_core and sha1_message_digest; depends on nothing else.
package sha1md_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumH    = 5;
  localparam int unsigned WinDepth = 16;
  localparam int unsigned RoundW  = 7;
  localparam int unsigned LastRound = 79;
  localparam int unsigned CountW  = 61;
  localparam int unsigned PosW    = 6;
  localparam int unsigned IdxW    = 3;

  localparam logic [7:0]      PadByte  = 8'h80;
  localparam logic [PosW-1:0] LastPos  = 6'd63;
  localparam logic [PosW-1:0] LenPos   = 6'd56;
  localparam logic [IdxW-1:0] LastIdx  = 3'(NumH - 1);

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumH-1:0][WordW-1:0] chain_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_ADD
  } core_state_e;

  // Control from the byte sequencer to the compression core
  typedef struct packed {
    logic push;   // shift one packed message word into the schedule window
    logic start;  // begin a compression on the current window
    logic init;   // load the chain value with the initial vector
  } core_ctl_t;

  function automatic word_t iv_word(input logic [IdxW-1:0] idx);
    word_t v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hC3D2E1F0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic word_t rotl1(input word_t x);
    return {x[WordW-2:0], x[WordW-1]};
  endfunction

  function automatic word_t rotl5(input word_t x);
    return {x[WordW-6:0], x[WordW-1:WordW-5]};
  endfunction

  function automatic word_t rotl30(input word_t x);
    return {x[1:0], x[WordW-1:2]};
  endfunction

  function automatic word_t round_k(input logic [RoundW-1:0] r);
    word_t k;
    if (r inside {[7'd0:7'd19]}) begin
      k = 32'h5A827999;
    end else if (r inside {[7'd20:7'd39]}) begin
      k = 32'h6ED9EBA1;
    end else if (r inside {[7'd40:7'd59]}) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic word_t round_f(input logic [RoundW-1:0] r, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (r inside {[7'd0:7'd19]}) begin
      f = (b & c) | (~b & d);
    end else if (r inside {[7'd40:7'd59]}) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ----- rtl/core/sha1md_core.sv -----
// SHA-1 compression core: 16-word schedule window, working registers a..e,
// one round adder reused for 80 rounds, and the chain value. Uses sha1md_pkg.
module sha1md_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha1md_pkg::core_ctl_t ctl_i,
  input  sha1md_pkg::word_t     word_i,
  output logic                  done_o,
  output sha1md_pkg::chain_t    chain_o
);

  sha1md_pkg::core_state_e state_q, state_d;
  logic [sha1md_pkg::RoundW-1:0] round_q, round_d;
  sha1md_pkg::chain_t work_q, work_d;
  sha1md_pkg::chain_t chain_q, chain_d;
  sha1md_pkg::word_t win_q [sha1md_pkg::WinDepth];

  sha1md_pkg::word_t new_w;
  sha1md_pkg::word_t round_sum;
  logic              shift_en;

  // Schedule word sixteen positions ahead, and the round adder
  always_comb begin
    new_w = sha1md_pkg::rotl1(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0]);
    round_sum = sha1md_pkg::rotl5(work_q[0])
              + sha1md_pkg::round_f(round_q, work_q[1], work_q[2], work_q[3])
              + work_q[4]
              + sha1md_pkg::round_k(round_q)
              + win_q[0];
  end

  // Sequence load, rounds and the final chain add
  always_comb begin
    state_d  = state_q;
    round_d  = round_q;
    work_d   = work_q;
    chain_d  = chain_q;
    shift_en = 1'b0;
    case (state_q)
      sha1md_pkg::CS_IDLE: begin
        shift_en = ctl_i.push;
        if (ctl_i.start) begin
          work_d  = chain_q;
          round_d = '0;
          state_d = sha1md_pkg::CS_ROUND;
        end
      end
      sha1md_pkg::CS_ROUND: begin
        shift_en  = 1'b1;
        work_d[4] = work_q[3];
        work_d[3] = work_q[2];
        work_d[2] = sha1md_pkg::rotl30(work_q[1]);
        work_d[1] = work_q[0];
        work_d[0] = round_sum;
        if (round_q == sha1md_pkg::RoundW'(sha1md_pkg::LastRound)) begin
          round_d = '0;
          state_d = sha1md_pkg::CS_ADD;
        end else begin
          round_d = round_q + 1'b1;
        end
      end
      sha1md_pkg::CS_ADD: begin
        for (int i = 0; i < sha1md_pkg::NumH; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        state_d = sha1md_pkg::CS_IDLE;
      end
      default: state_d = sha1md_pkg::CS_IDLE;
    endcase
    if (ctl_i.init) begin
      for (int i = 0; i < sha1md_pkg::NumH; i++) begin
        chain_d[i] = sha1md_pkg::iv_word(sha1md_pkg::IdxW'(i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1md_pkg::CS_IDLE;
      round_q <= '0;
      work_q  <= '0;
      for (int i = 0; i < sha1md_pkg::NumH; i++) begin
        chain_q[i] <= sha1md_pkg::iv_word(sha1md_pkg::IdxW'(i));
      end
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      work_q  <= work_d;
      chain_q <= chain_d;
    end
  end

  // Advance the schedule window: message words in while loading, W[t+16] in rounds
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < sha1md_pkg::WinDepth - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sha1md_pkg::WinDepth-1] <= (state_q == sha1md_pkg::CS_ROUND) ? new_w : word_i;
    end
  end

  assign done_o  = (state_q == sha1md_pkg::CS_ADD);
  assign chain_o = chain_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == sha1md_pkg::CS_IDLE)
    else $error("compression started while core busy");

  a_round_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1md_pkg::CS_ROUND && round_q == 7'd79) |=> done_o)
    else $error("final add did not follow the last round");

  a_round_zero_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != sha1md_pkg::CS_ROUND |-> round_q == '0)
    else $error("round counter left nonzero outside rounds");

endmodule

// ----- rtl/core/sha1_message_digest.sv -----
// SHA-1 digest of a byte stream. Bytes that do not finish a 64-byte block
// transfer back to back; a block-closing byte holds the input off while the
// 80 rounds on the shared round adder and the chain add run. Closing the
// message feeds pad bytes at 1 per cycle (up to 72), with a compression after
// each padded block, then 5 digest transfers. Reset loads the initial vector,
// clears counters and returns to idle; no clearing pass. Uses sha1md_pkg, sha1md_core.
module sha1_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1md_pkg::state_e state_q, state_d;
  logic [sha1md_pkg::PosW-1:0]   pos_q, pos_d;
  logic [sha1md_pkg::CountW-1:0] count_q, count_d;
  logic [23:0]                   pack_q;
  logic                          first_q, first_d;
  logic                          len_blk_q, len_blk_d;
  logic                          pend_q, pend_d;
  logic                          fin_q, fin_d;
  logic [sha1md_pkg::IdxW-1:0]   idx_q, idx_d;

  logic                      in_xfer, out_xfer;
  logic                      byte_push;
  logic [7:0]                byte_val, pad_byte, len_byte;
  logic [63:0]               len_bits;
  logic [sha1md_pkg::PosW-1:0] pos_next;
  sha1md_pkg::core_ctl_t     core_ctl;
  sha1md_pkg::word_t         core_word;
  logic                      core_done;
  sha1md_pkg::chain_t        chain;

  assign in_ready_o  = (state_q == sha1md_pkg::ST_IDLE);
  assign out_valid_o = (state_q == sha1md_pkg::ST_OUT);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign out_xfer    = out_valid_o & out_ready_i;

  // Pick the byte to pack: message byte, or 0x80 / zero / length while padding
  always_comb begin
    len_bits = {count_q, 3'b000};
    len_byte = len_bits[8*(7 - 32'(pos_q[2:0])) +: 8];
    if (first_q) begin
      pad_byte = sha1md_pkg::PadByte;
    end else if (len_blk_q && pos_q >= sha1md_pkg::LenPos) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
    byte_push = (in_xfer & has_byte_i) | (state_q == sha1md_pkg::ST_PAD);
    byte_val  = (state_q == sha1md_pkg::ST_PAD) ? pad_byte : msg_byte_i;
    core_word = {pack_q, byte_val};
    core_ctl.push  = byte_push && (pos_q[1:0] == 2'd3);
    core_ctl.start = byte_push && (pos_q == sha1md_pkg::LastPos);
    core_ctl.init  = out_xfer && (idx_q == sha1md_pkg::LastIdx);
    pos_next = has_byte_i ? pos_q + 1'b1 : pos_q;
  end

  // Next state: absorb, pad, wait for compression, emit digest words
  always_comb begin
    state_d   = state_q;
    pos_d     = byte_push ? pos_q + 1'b1 : pos_q;
    count_d   = (in_xfer && has_byte_i) ? count_q + 1'b1 : count_q;
    first_d   = first_q;
    len_blk_d = len_blk_q;
    pend_d    = pend_q;
    fin_d     = fin_q;
    idx_d     = idx_q;
    case (state_q)
      sha1md_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (end_of_message_i) begin
            first_d   = 1'b1;
            pend_d    = 1'b1;
            len_blk_d = (pos_next < sha1md_pkg::LenPos);
          end
          if (has_byte_i && pos_q == sha1md_pkg::LastPos) begin
            state_d = sha1md_pkg::ST_COMP;
          end else if (end_of_message_i) begin
            state_d = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        first_d = 1'b0;
        if (pos_q == sha1md_pkg::LastPos) begin
          state_d = sha1md_pkg::ST_COMP;
          if (len_blk_q) begin
            fin_d = 1'b1;
          end else begin
            len_blk_d = 1'b1;
          end
        end
      end
      sha1md_pkg::ST_COMP: begin
        if (core_done) begin
          if (fin_q) begin
            state_d = sha1md_pkg::ST_OUT;
          end else if (pend_q) begin
            state_d = sha1md_pkg::ST_PAD;
          end else begin
            state_d = sha1md_pkg::ST_IDLE;
          end
        end
      end
      sha1md_pkg::ST_OUT: begin
        if (out_xfer) begin
          if (idx_q == sha1md_pkg::LastIdx) begin
            idx_d     = '0;
            pos_d     = '0;
            count_d   = '0;
            first_d   = 1'b0;
            len_blk_d = 1'b0;
            pend_d    = 1'b0;
            fin_d     = 1'b0;
            state_d   = sha1md_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = sha1md_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1md_pkg::ST_IDLE;
      pos_q     <= '0;
      count_q   <= '0;
      first_q   <= 1'b0;
      len_blk_q <= 1'b0;
      pend_q    <= 1'b0;
      fin_q     <= 1'b0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      count_q   <= count_d;
      first_q   <= first_d;
      len_blk_q <= len_blk_d;
      pend_q    <= pend_d;
      fin_q     <= fin_d;
      idx_q     <= idx_d;
    end
  end

  // Hold the three earlier bytes of the word being packed, big-endian
  always_ff @(posedge clk_i) begin
    if (byte_push) begin
      pack_q <= {pack_q[15:0], byte_val};
    end
  end

  sha1md_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (core_ctl),
    .word_i  (core_word),
    .done_o  (core_done),
    .chain_o (chain)
  );

  // Select the digest word for the current transfer
  always_comb begin
    case (idx_q)
      3'd0:    digest_word_o = chain[0];
      3'd1:    digest_word_o = chain[1];
      3'd2:    digest_word_o = chain[2];
      3'd3:    digest_word_o = chain[3];
      3'd4:    digest_word_o = chain[4];
      default: digest_word_o = '0;
    endcase
  end

  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == sha1md_pkg::LastIdx);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while digest pending");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (word_index_o <= sha1md_pkg::LastIdx))
    else $error("digest word index out of range");

  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_word_o) |=> (in_ready_o && pos_q == '0 && count_q == '0))
    else $error("block not restarted after last digest word");

  a_done_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> state_q == sha1md_pkg::ST_COMP)
    else $error("compression finished outside the wait state");

  a_start_at_block_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_ctl.start |-> core_ctl.push && state_d == sha1md_pkg::ST_COMP)
    else $error("compression started without a full block");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for sha1_message_digest: streams byte messages, predicts each
// digest with an internal SHA-1 model and checks every digest word transfer.
// Depends on sha1md_pkg and the sha1_message_digest RTL only.
module tb;

  localparam int unsigned IdlePct = 36;

  // Initial vector and known digests, packed h4 down to h0
  localparam sha1md_pkg::chain_t IvWords =
    {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};
  localparam sha1md_pkg::chain_t DigEmpty =
    {32'hAFD80709, 32'h95601890, 32'h3255BFEF, 32'h5E6B4B0D, 32'hDA39A3EE};
  localparam sha1md_pkg::chain_t DigAbc =
    {32'h9CD0D89D, 32'h7850C26C, 32'hBA3E2571, 32'h4706816A, 32'hA9993E36};

  typedef struct {
    logic [7:0]         b;
    logic               hb;
    logic               eom;
    logic               known;
    sha1md_pkg::chain_t dig;
  } stim_row_t;

  typedef struct {
    sha1md_pkg::word_t           word;
    logic [sha1md_pkg::IdxW-1:0] idx;
    logic                        last;
  } digest_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  msg_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // Digest model state
  sha1md_pkg::word_t  blk [16];
  sha1md_pkg::chain_t hval = IvWords;
  logic [60:0]        nbytes = '0;

  digest_exp_t digest_q [$];
  digest_exp_t head;
  int          mismatches = 0;
  bit          no_gaps = 1'b0;

  sha1_message_digest dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .msg_byte_i       (msg_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  always #10 clk_i = ~clk_i;

  // Run the 80 rounds on the current block and fold into the chain value
  function automatic void run_compression();
    sha1md_pkg::word_t w [80];
    sha1md_pkg::word_t a, b, c, d, e, f, k, t;
    int                r;
    for (r = 0; r < 16; r++) w[r] = blk[r];
    for (r = 16; r < 80; r++) begin
      t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = hval[0]; b = hval[1]; c = hval[2]; d = hval[3]; e = hval[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hval[0] += a; hval[1] += b; hval[2] += c; hval[3] += d; hval[4] += e;
  endfunction

  // Absorb one item; on the closing item pad, finish and return the digest
  function automatic bit absorb_item(input logic [7:0] b, input logic hb,
                                     input logic eom, output sha1md_pkg::chain_t dig);
    logic [5:0]  pos;
    logic [63:0] bitlen;
    int          p;
    dig = '0;
    if (hb) begin
      pos = nbytes[5:0];
      blk[pos[5:2]][8*(3-pos[1:0]) +: 8] = b;
      nbytes = nbytes + 61'd1;
      if (pos == sha1md_pkg::LastPos) run_compression();
    end
    if (!eom) return 1'b0;
    pos = nbytes[5:0];
    bitlen = {nbytes, 3'b000};
    for (p = pos; p < 64; p++)
      blk[p/4][8*(3-p%4) +: 8] = (p == pos) ? sha1md_pkg::PadByte : 8'h00;
    // No room for the length: close this block and start a zero one
    if (pos >= sha1md_pkg::LenPos) begin
      run_compression();
      for (p = 0; p < 16; p++) blk[p] = '0;
    end
    blk[14] = bitlen[63:32];
    blk[15] = bitlen[31:0];
    run_compression();
    dig = hval;
    hval = IvWords;
    nbytes = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input sha1md_pkg::word_t got,
                                 input sha1md_pkg::word_t want);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one item, hold it until the transfer, then queue its digest words
  task automatic send_item(input logic [7:0] b, input logic hb, input logic eom,
                           input logic known, input sha1md_pkg::chain_t known_dig);
    sha1md_pkg::chain_t dig;
    while (!no_gaps && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    msg_byte_i       <= b;
    has_byte_i       <= hb;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (absorb_item(b, hb, eom, dig)) begin
      if (known) dig = known_dig;
      for (int i = 0; i < sha1md_pkg::NumH; i++)
        digest_q.push_back('{dig[i], sha1md_pkg::IdxW'(i),
                             sha1md_pkg::IdxW'(i) == sha1md_pkg::LastIdx});
    end
    @(negedge clk_i);
  endtask

  // Stall the digest side at random
  always @(negedge clk_i) begin
    out_ready_i <= no_gaps || ($urandom_range(99) >= IdlePct);
  end

  // Check each digest word transfer against the oldest expected word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", digest_word_o, '0);
      end else begin
        head = digest_q.pop_front();
        if (digest_word_o !== head.word)
          report_mismatch("digest_word", digest_word_o, head.word);
        if (word_index_o !== head.idx)
          report_mismatch("word_index", sha1md_pkg::word_t'(word_index_o),
                          sha1md_pkg::word_t'(head.idx));
        if (last_word_o !== head.last)
          report_mismatch("last_word", sha1md_pkg::word_t'(last_word_o),
                          sha1md_pkg::word_t'(head.last));
      end
    end
  end

  initial begin : stim
    stim_row_t  dir_rows [12];
    int         items;
    int         msgs;
    int         len;
    int         long_lens [6];
    bit         sep_close;

    long_lens = '{55, 56, 63, 64, 65, 119};
    // Directed messages: empty items, empty message, byte on the closing item
    dir_rows = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, '0},       // empty item right after reset
      '{8'h00, 1'b0, 1'b1, 1'b1, DigEmpty}, // empty message
      '{8'h61, 1'b1, 1'b0, 1'b0, '0},
      '{8'h3C, 1'b0, 1'b0, 1'b0, '0},       // empty item inside a message
      '{8'h62, 1'b1, 1'b0, 1'b0, '0},
      '{8'h63, 1'b1, 1'b1, 1'b1, DigAbc},   // "abc", closed on its last byte
      '{8'h00, 1'b1, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
      '{8'hA5, 1'b0, 1'b1, 1'b0, '0},       // closed by an item with no byte
      '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
      '{8'h5A, 1'b0, 1'b1, 1'b1, DigEmpty}, // empty message, stray byte field
      '{8'h00, 1'b1, 1'b1, 1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r])
      send_item(dir_rows[r].b, dir_rows[r].hb, dir_rows[r].eom,
                dir_rows[r].known, dir_rows[r].dig);

    // Random messages: mostly short, some around the block and padding borders
    items = 0;
    msgs  = 0;
    while (items < 130 || msgs < 3) begin
      if (msgs == 1) len = 100;
      else if ($urandom_range(9) < 3) len = long_lens[$urandom_range(5)];
      else len = $urandom_range(12);
      no_gaps   = (msgs == 1);
      sep_close = (len == 0) || $urandom_range(1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(7) == 0)
          send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
        send_item(8'($urandom), 1'b1, !sep_close && (i == len - 1), 1'b0, '0);
        items++;
      end
      if (sep_close) begin
        send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
        items++;
      end
      msgs++;
    end
    no_gaps = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then watch for stray words
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hold a hard limit on the run
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
